>>> hw/rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// shared types, codes and sizes of the snooping coherence cache controller
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int LINES      = 64;
    localparam int IDX_W      = $clog2(LINES);
    localparam int TAG_W      = 30;
    localparam int STAMP_W    = 32;
    localparam int COST_W     = 7;
    localparam int BSL_W      = 4;
    localparam int BSL_RESET  = 6;
    localparam int BSL_MIN    = 2;
    localparam int BSL_MAX    = 12;

    // command codes
    localparam logic [2:0] CMD_RD     = 3'd0;
    localparam logic [2:0] CMD_WR     = 3'd1;
    localparam logic [2:0] CMD_BUSRD  = 3'd2;
    localparam logic [2:0] CMD_BUSRDX = 3'd3;
    localparam logic [2:0] CMD_BUSUPG = 3'd4;

    // line states
    localparam logic [2:0] ST_I = 3'd0;
    localparam logic [2:0] ST_S = 3'd1;
    localparam logic [2:0] ST_E = 3'd2;
    localparam logic [2:0] ST_M = 3'd3;
    localparam logic [2:0] ST_O = 3'd4;

    // bus actions
    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_RD    = 2'd1;
    localparam logic [1:0] BUS_RDX   = 2'd2;
    localparam logic [1:0] BUS_UPGR  = 2'd3;

    // costs
    localparam logic [COST_W-1:0] COST_NONE = 7'd0;
    localparam logic [COST_W-1:0] COST_HIT  = 7'd1;
    localparam logic [COST_W-1:0] COST_WHIT = 7'd3;
    localparam logic [COST_W-1:0] COST_C2C  = 7'd15;
    localparam logic [COST_W-1:0] COST_MEM  = 7'd100;

    // register indexes
    localparam logic REG_PROTOCOL = 1'b0;
    localparam logic REG_BLOCK    = 1'b1;

    typedef struct packed {
        logic capture;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_last;
    } ctrl_status_t;

endpackage

>>> hw/rtl/scc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_ctrl
// sequencer: capture, scan of all lines, drain, finish
// ----------------------------------------------------------------------------
module scc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output scc_pkg::ctrl_cmd_t    cmd,
    input  scc_pkg::ctrl_status_t status
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } fsm_t;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/scc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_datapath
// line memories, tag/lru scan and coherence update
// ----------------------------------------------------------------------------
module scc_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  scc_pkg::ctrl_cmd_t        cmd,
    output scc_pkg::ctrl_status_t     status,
    input  logic [2:0]                command,
    input  logic [31:0]               address,
    input  logic                      other_copy_exists,
    input  logic                      protocol_mode,
    input  logic [scc_pkg::BSL_W-1:0] block_size_log2,
    output logic                      done,
    output logic                      hit,
    output logic [2:0]                new_state,
    output logic [1:0]                bus_request,
    output logic                      memory_fetch,
    output logic                      write_back,
    output logic                      flushed,
    output logic                      invalidated,
    output logic [scc_pkg::COST_W-1:0] cost
);
    import scc_pkg::*;

    logic [2:0]         state_mem [LINES];
    logic [TAG_W-1:0]   tag_mem   [LINES];
    logic [STAMP_W-1:0] stamp_mem [LINES];
    logic [LINES-1:0]   valid_reg;

    logic [2:0]         cmd_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               copy_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   idx_d_reg;
    logic               dv_reg;
    logic [2:0]         st_q;
    logic               vld_q;
    logic [TAG_W-1:0]   tg_q;
    logic [STAMP_W-1:0] sp_q;

    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [2:0]         hit_st_reg;
    logic               inv_found_reg;
    logic [IDX_W-1:0]   inv_idx_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [IDX_W-1:0]   lru_idx_reg;
    logic [2:0]         lru_st_reg;

    logic [BSL_W-1:0]   sh;
    logic [2:0]         st_eff;
    logic [STAMP_W-1:0] clock_next;

    // result and write controls
    logic               r_hit, r_fetch, r_wb, r_fl, r_inv;
    logic [2:0]         r_ns;
    logic [1:0]         r_bus;
    logic [COST_W-1:0]  r_cost;
    logic               wr_state, wr_tag, wr_stamp, is_proc;
    logic [IDX_W-1:0]   wr_idx;
    logic [2:0]         victim_st;
    logic               moesi;

    always_comb
    begin
        if (block_size_log2 < BSL_W'(BSL_MIN))
            sh = BSL_W'(BSL_MIN);
        else if (block_size_log2 > BSL_W'(BSL_MAX))
            sh = BSL_W'(BSL_MAX);
        else
            sh = block_size_log2;
    end

    assign status.issue_last = (rd_idx_reg == IDX_W'(LINES - 1));
    assign st_eff            = vld_q ? st_q : ST_I;
    assign clock_next        = clock_reg + STAMP_W'(1);

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            st_q <= state_mem[rd_idx_reg];
            tg_q <= tag_mem[rd_idx_reg];
            sp_q <= stamp_mem[rd_idx_reg];
        end
        if (cmd.finish && wr_state)
            state_mem[wr_idx] <= r_ns;
        if (cmd.finish && wr_tag)
            tag_mem[wr_idx] <= tag_reg;
        if (cmd.finish && wr_stamp)
            stamp_mem[wr_idx] <= clock_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            clock_reg  <= '0;
            rd_idx_reg <= '0;
            dv_reg     <= 1'b0;
            vld_q      <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            dv_reg <= cmd.scan;
            done   <= cmd.finish;
            if (cmd.scan)
                vld_q <= valid_reg[rd_idx_reg];
            if (cmd.capture)
                rd_idx_reg <= '0;
            else if (cmd.scan)
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            if (cmd.finish && wr_state)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.finish && is_proc)
                clock_reg <= clock_next;
        end
    end

    // item capture and scan evaluation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg       <= command;
            tag_reg       <= TAG_W'(address >> sh);
            copy_reg      <= other_copy_exists;
            found_reg     <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        else if (dv_reg)
        begin
            if (!found_reg && st_eff != ST_I && tg_q == tag_reg)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= idx_d_reg;
                hit_st_reg  <= st_eff;
            end
            if (!inv_found_reg && st_eff == ST_I)
            begin
                inv_found_reg <= 1'b1;
                inv_idx_reg   <= idx_d_reg;
            end
            if (idx_d_reg == '0 || sp_q <= best_reg)
            begin
                best_reg    <= sp_q;
                lru_idx_reg <= idx_d_reg;
                lru_st_reg  <= st_eff;
            end
        end
        if (cmd.scan)
            idx_d_reg <= rd_idx_reg;
    end

    // coherence decision
    always_comb
    begin
        r_hit    = found_reg;
        r_ns     = found_reg ? hit_st_reg : ST_I;
        r_bus    = BUS_NONE;
        r_fetch  = 1'b0;
        r_wb     = 1'b0;
        r_fl     = 1'b0;
        r_inv    = 1'b0;
        r_cost   = COST_NONE;
        wr_state = 1'b0;
        wr_tag   = 1'b0;
        wr_stamp = 1'b0;
        is_proc  = 1'b0;
        wr_idx   = hit_idx_reg;
        victim_st = inv_found_reg ? ST_I : lru_st_reg;
        moesi    = protocol_mode || (hit_st_reg == ST_O);
        if (cmd_reg > CMD_BUSUPG)
        begin
            r_hit = 1'b0;
            r_ns  = ST_I;
        end
        else if (cmd_reg == CMD_RD || cmd_reg == CMD_WR)
        begin
            is_proc  = 1'b1;
            wr_state = 1'b1;
            wr_stamp = 1'b1;
            if (found_reg)
            begin
                if (cmd_reg == CMD_RD)
                    r_cost = COST_HIT;
                else
                begin
                    if (hit_st_reg == ST_S || hit_st_reg == ST_O)
                        r_bus = BUS_UPGR;
                    r_ns   = ST_M;
                    r_cost = COST_WHIT;
                end
            end
            else
            begin
                wr_tag = 1'b1;
                wr_idx = inv_found_reg ? inv_idx_reg : lru_idx_reg;
                r_wb   = (victim_st == ST_M) || (victim_st == ST_O);
                if (cmd_reg == CMD_RD)
                begin
                    r_bus = BUS_RD;
                    if (copy_reg)
                    begin
                        r_ns   = ST_S;
                        r_cost = COST_C2C;
                    end
                    else
                    begin
                        r_ns    = ST_E;
                        r_fetch = 1'b1;
                        r_cost  = COST_MEM;
                    end
                end
                else
                begin
                    r_bus   = BUS_RDX;
                    r_ns    = ST_M;
                    r_fetch = 1'b1;
                    r_cost  = COST_MEM;
                end
            end
        end
        else if (found_reg)
        begin
            wr_state = 1'b1;
            if (cmd_reg == CMD_BUSRD)
            begin
                if (hit_st_reg == ST_M)
                begin
                    r_ns   = moesi ? ST_O : ST_S;
                    r_fl   = 1'b1;
                    r_wb   = 1'b1;
                    r_cost = COST_MEM;
                end
                else if (hit_st_reg == ST_O)
                begin
                    r_fl   = 1'b1;
                    r_cost = COST_C2C;
                end
                else if (hit_st_reg == ST_E)
                begin
                    r_ns   = ST_S;
                    r_cost = COST_C2C;
                    r_fl   = !moesi;
                end
                else if (!moesi)
                begin
                    r_fl   = 1'b1;
                    r_cost = COST_C2C;
                end
            end
            else if (cmd_reg == CMD_BUSRDX)
            begin
                r_ns  = ST_I;
                r_inv = 1'b1;
                if (hit_st_reg == ST_S)
                begin
                    if (!moesi)
                    begin
                        r_fl   = 1'b1;
                        r_cost = COST_C2C;
                    end
                end
                else
                begin
                    r_fl   = 1'b1;
                    r_cost = COST_C2C;
                    if (hit_st_reg == ST_M && !moesi)
                    begin
                        r_wb   = 1'b1;
                        r_cost = COST_MEM;
                    end
                end
            end
            else
            begin
                if (hit_st_reg == ST_S || hit_st_reg == ST_O)
                begin
                    r_ns  = ST_I;
                    r_inv = 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit          <= r_hit;
            new_state    <= r_ns;
            bus_request  <= r_bus;
            memory_fetch <= r_fetch;
            write_back   <= r_wb;
            flushed      <= r_fl;
            invalidated  <= r_inv;
            cost         <= r_cost;
        end
    end

endmodule

>>> hw/rtl/snooping_coherence_cache_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snooping_coherence_cache_controller_unit
// fully associative 64-line cache with lru and mesi/moesi snooping coherence
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     start & !busy             command, address, other_copy_exists
//  result    done (one cycle)          hit .. cost
//  config    psel&penable&pwrite       paddr, pwdata / prdata
//
//  an item passes through a capture, a scan of every line of the
//  line memories through their single read port, a drain and a finish;
//  the result strobe follows in the next cycle, when the next item may start
//  reset clears all lines to invalid via per-line valid flops, no clearing pass
//  the receiver cannot stall: done is high for one cycle only
module snooping_coherence_cache_controller_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] address,
    input  logic        other_copy_exists,
    output logic        done,
    output logic        hit,
    output logic [2:0]  new_state,
    output logic [1:0]  bus_request,
    output logic        memory_fetch,
    output logic        write_back,
    output logic        flushed,
    output logic        invalidated,
    output logic [6:0]  cost,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scc_pkg::*;

    // configuration registers
    logic             protocol_mode_reg;
    logic [BSL_W-1:0] block_size_log2_reg;
    logic             cfg_wr;

    ctrl_cmd_t    ctl;
    ctrl_status_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register index is paddr[2], byte offset bits ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_mode_reg   <= 1'b0;
            block_size_log2_reg <= BSL_W'(BSL_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_PROTOCOL: protocol_mode_reg   <= pwdata[0];
                REG_BLOCK:    block_size_log2_reg <= pwdata[BSL_W-1:0];
                default:      ;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_PROTOCOL: prdata = {31'd0, protocol_mode_reg};
            REG_BLOCK:    prdata = {{(32 - BSL_W){1'b0}}, block_size_log2_reg};
            default:      prdata = '0;
        endcase
    end

    // sequencer
    scc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (ctl),
        .status (sts)
    );

    // memories, scan and coherence decision
    scc_datapath u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (ctl),
        .status            (sts),
        .command           (command),
        .address           (address),
        .other_copy_exists (other_copy_exists),
        .protocol_mode     (protocol_mode_reg),
        .block_size_log2   (block_size_log2_reg),
        .done              (done),
        .hit               (hit),
        .new_state         (new_state),
        .bus_request       (bus_request),
        .memory_fetch      (memory_fetch),
        .write_back        (write_back),
        .flushed           (flushed),
        .invalidated       (invalidated),
        .cost              (cost)
    );

endmodule
